FILE: rtl/cap_pkg.sv
// ============================================================================
// Conflict-aware priority select package
// Shared widths, codes and control structures for the selection block.
// ============================================================================
package cap_pkg;

    // Default configuration of the entry file.
    localparam int ENTRIES_DEF       = 16;
    localparam int PRIORITY_BITS_DEF = 32;

    // Fixed field widths of the input and result words.
    localparam int IDX_IN_W  = 4;
    localparam int PRIO_IN_W = 32;
    localparam int ROW_W     = 16;
    localparam int LIMIT_W   = 5;
    localparam int SEL_W     = 4;
    localparam int CNT_W     = 5;

    // Upper bound on results of one select word.
    localparam int MAX_RESULTS = 16;

    // Action codes of an input word.
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SELECT = 1'b1;

    // Request from the top-level control to the sort and pick engine.
    typedef struct packed {
        logic               start;
        logic [LIMIT_W-1:0] limit;
    } t_eng_ctl;

    // Status returned by the engine when a selection is complete.
    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] count;
    } t_eng_stat;

endpackage

FILE: rtl/cap_entry_store.sv
// ============================================================================
// Entry store
// Holds the priority and conflict row of every entry, cleared by reset.
// ============================================================================
module cap_entry_store #(
    parameter int ENTRIES       = cap_pkg::ENTRIES_DEF,
    parameter int PRIORITY_BITS = cap_pkg::PRIORITY_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic [$clog2(ENTRIES)-1:0]  i_wr_addr,
    input  logic [PRIORITY_BITS-1:0]    i_wr_prio,
    input  logic [cap_pkg::ROW_W-1:0]   i_wr_row,
    input  logic [$clog2(ENTRIES)-1:0]  i_prio_addr,
    output logic [PRIORITY_BITS-1:0]    o_prio_data,
    input  logic [$clog2(ENTRIES)-1:0]  i_row_addr,
    output logic [ENTRIES-1:0]          o_row_data
);
    import cap_pkg::*;

    logic [PRIORITY_BITS-1:0] r_prio [ENTRIES];
    logic [ROW_W-1:0]         r_row  [ENTRIES];
    logic [ROW_W+ENTRIES-1:0] row_pad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < ENTRIES; e++) begin
                r_prio[e] <= '0;
                r_row[e]  <= '0;
            end
        end else if (i_wr_en) begin
            r_prio[i_wr_addr] <= i_wr_prio;
            r_row[i_wr_addr]  <= i_wr_row;
        end
    end

    // Conflict bits beyond the entry count are never consulted; rows are
    // widened or cut to one bit per entry.
    assign row_pad     = {{ENTRIES{1'b0}}, r_row[i_row_addr]};
    assign o_row_data  = row_pad[ENTRIES-1:0];
    assign o_prio_data = r_prio[i_prio_addr];

endmodule

FILE: rtl/cap_sort_engine.sv
// ============================================================================
// Sort and pick engine
// Exchange sort with one shared comparator, then a greedy conflict-free walk.
// ============================================================================
module cap_sort_engine #(
    parameter int ENTRIES       = cap_pkg::ENTRIES_DEF,
    parameter int PRIORITY_BITS = cap_pkg::PRIORITY_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cap_pkg::t_eng_ctl           i_ctl,
    output cap_pkg::t_eng_stat          o_stat,
    output logic [$clog2(ENTRIES)-1:0]  o_prio_addr,
    input  logic [PRIORITY_BITS-1:0]    i_prio_data,
    output logic [$clog2(ENTRIES)-1:0]  o_row_addr,
    input  logic [ENTRIES-1:0]          i_row_data,
    input  logic [cap_pkg::SEL_W-1:0]   i_sel_addr,
    output logic [$clog2(ENTRIES)-1:0]  o_sel_data
);
    import cap_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(ENTRIES - 1);
    localparam logic [IDX_W-1:0] PEN_POS  = IDX_W'(ENTRIES - 2);

    typedef enum logic [2:0] {
        E_IDLE,
        E_COPY,
        E_SORT,
        E_NEXT,
        E_PICK
    } t_eng_state;

    t_eng_state               r_state;
    logic [IDX_W-1:0]         r_i;
    logic [IDX_W-1:0]         r_j;
    logic [IDX_W-1:0]         r_cur_idx;
    logic [PRIORITY_BITS-1:0] r_cur_prio;
    logic [LIMIT_W-1:0]       r_limit;
    logic [CNT_W-1:0]         r_cnt;
    logic [ENTRIES-1:0]       r_mask;
    logic                     r_done;

    logic [IDX_W-1:0]         r_ord_idx  [ENTRIES];
    logic [PRIORITY_BITS-1:0] r_ord_prio [ENTRIES];
    logic [IDX_W-1:0]         r_sel      [MAX_RESULTS];
    logic [IDX_W-1:0]         r_sel_q;

    logic [IDX_W-1:0]         rd_pos;
    logic [IDX_W-1:0]         rd_idx;
    logic [PRIORITY_BITS-1:0] rd_prio;
    logic                     gt;
    logic                     hit;
    logic                     keep;
    logic                     ord_we;
    logic [IDX_W-1:0]         ord_waddr;
    logic [IDX_W-1:0]         ord_widx;
    logic [PRIORITY_BITS-1:0] ord_wprio;

    // One read port on the order list: the next pass head while stepping
    // passes, otherwise the running position.
    assign rd_pos  = (r_state == E_NEXT) ? (r_i + IDX_W'(1)) : r_j;
    assign rd_idx  = r_ord_idx[rd_pos];
    assign rd_prio = r_ord_prio[rd_pos];

    // The shared comparator: is the entry at j strictly above the one at i?
    assign gt   = rd_prio > r_cur_prio;
    assign hit  = |(i_row_data & r_mask);
    assign keep = (r_state == E_PICK) && !hit;

    assign o_prio_addr = r_j;
    assign o_row_addr  = rd_idx;

    always_comb begin
        ord_we    = 1'b0;
        ord_waddr = r_j;
        ord_widx  = r_cur_idx;
        ord_wprio = r_cur_prio;
        case (r_state)
            E_COPY: begin
                ord_we    = 1'b1;
                ord_widx  = r_j;
                ord_wprio = i_prio_data;
            end
            E_SORT: begin
                ord_we = gt;
            end
            E_NEXT: begin
                ord_we    = 1'b1;
                ord_waddr = r_i;
            end
            default: begin
                ord_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            r_ord_idx[ord_waddr]  <= ord_widx;
            r_ord_prio[ord_waddr] <= ord_wprio;
        end
        if (keep) begin
            r_sel[r_cnt[SEL_W-1:0]] <= rd_idx;
        end
        r_sel_q <= r_sel[i_sel_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_mask  <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_limit <= '0;
        end else begin
            case (r_state)
                E_IDLE: begin
                    r_done <= 1'b0;
                    if (i_ctl.start) begin
                        r_limit <= i_ctl.limit;
                        r_j     <= '0;
                        r_state <= E_COPY;
                    end
                end
                E_COPY: begin
                    if (r_j == '0) begin
                        r_cur_idx  <= '0;
                        r_cur_prio <= i_prio_data;
                    end
                    if (r_j == LAST_POS) begin
                        r_i     <= '0;
                        r_j     <= IDX_W'(1);
                        r_state <= E_SORT;
                    end else begin
                        r_j <= r_j + IDX_W'(1);
                    end
                end
                E_SORT: begin
                    if (gt) begin
                        r_cur_idx  <= rd_idx;
                        r_cur_prio <= rd_prio;
                    end
                    if (r_j == LAST_POS) begin
                        r_state <= E_NEXT;
                    end else begin
                        r_j <= r_j + IDX_W'(1);
                    end
                end
                E_NEXT: begin
                    if (r_i == PEN_POS) begin
                        r_j     <= '0;
                        r_cnt   <= '0;
                        r_mask  <= '0;
                        r_state <= E_PICK;
                    end else begin
                        r_cur_idx  <= rd_idx;
                        r_cur_prio <= rd_prio;
                        r_i        <= r_i + IDX_W'(1);
                        r_j        <= r_i + IDX_W'(2);
                        r_state    <= E_SORT;
                    end
                end
                E_PICK: begin
                    if (!hit) begin
                        r_cnt          <= r_cnt + CNT_W'(1);
                        r_mask[rd_idx] <= 1'b1;
                    end
                    if ((!hit && (r_cnt + CNT_W'(1) == CNT_W'(r_limit)))
                            || (r_j == LAST_POS)) begin
                        r_done  <= 1'b1;
                        r_state <= E_IDLE;
                    end else begin
                        r_j <= r_j + IDX_W'(1);
                    end
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    assign o_stat.done  = r_done;
    assign o_stat.count = r_cnt;
    assign o_sel_data   = r_sel_q;

endmodule

FILE: rtl/conflict_aware_priority_select_top.sv
// ============================================================================
// Conflict-aware priority select, top level
// Load words fill the entry file; select words sort the entries and return
// the chosen conflict-free entries one result word at a time.
// Operation: a load word writes its entry. A select word with a nonzero limit
//   copies the priorities into the order list, sorts it with exchange passes
//   and walks the sorted order to pick entries; each result word is then read
//   from the pick list and sent.
// Input: one word at a time; the next word is taken once the block is idle.
// Reset: synchronous, active low; clears the entry file, control and output valid.
// ============================================================================
module conflict_aware_priority_select_top #(
    parameter int ENTRIES       = cap_pkg::ENTRIES_DEF,
    parameter int PRIORITY_BITS = cap_pkg::PRIORITY_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_action,
    input  logic [cap_pkg::IDX_IN_W-1:0]  i_entry_index,
    input  logic [cap_pkg::PRIO_IN_W-1:0] i_priority_req,
    input  logic [cap_pkg::ROW_W-1:0]     i_conflict_row,
    input  logic [cap_pkg::LIMIT_W-1:0]   i_select_limit,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [cap_pkg::IDX_IN_W-1:0]  o_selected_index,
    output logic [cap_pkg::SEL_W-1:0]     o_slot,
    output logic                          o_none_selected,
    output logic [cap_pkg::CNT_W-1:0]     o_total_selected,
    output logic                          o_is_last
);
    import cap_pkg::*;

    localparam int IDX_W   = $clog2(ENTRIES);
    // A select keeps at most this many entries.
    localparam int LIM_CAP = (ENTRIES < MAX_RESULTS) ? ENTRIES : MAX_RESULTS;

    typedef enum logic [1:0] {
        T_IDLE,
        T_RUN,
        T_READ,
        T_SEND
    } t_top_state;

    t_top_state           r_state;
    logic [CNT_W-1:0]     r_total;
    logic [SEL_W-1:0]     r_k;
    logic                 r_out_valid;
    logic [IDX_IN_W-1:0]  r_out_index;
    logic [SEL_W-1:0]     r_out_slot;
    logic                 r_out_none;
    logic [CNT_W-1:0]     r_out_total;
    logic                 r_out_last;

    logic                 in_acc;
    logic                 out_free;
    logic                 load_wr;
    logic [LIMIT_W-1:0]   lim_sat;
    logic                 res_last;
    t_eng_ctl             eng_ctl;
    t_eng_stat            eng_stat;
    logic [IDX_W-1:0]     prio_addr;
    logic [PRIORITY_BITS-1:0] prio_data;
    logic [IDX_W-1:0]     row_addr;
    logic [ENTRIES-1:0]   row_data;
    logic [IDX_W-1:0]     sel_data;

    // Input words are taken only while the block is idle. The output
    // register decouples the two sides, so the next word may enter while
    // the final result still waits downstream.
    assign o_in_stall = (r_state != T_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Loads whose index lies beyond the entry file are dropped.
    assign load_wr = in_acc && (i_action == ACT_LOAD)
                     && (int'(i_entry_index) < ENTRIES);

    // Saturate the limit to the entry count and the result bound.
    always_comb begin
        lim_sat = i_select_limit;
        if (int'(i_select_limit) > LIM_CAP) begin
            lim_sat = LIMIT_W'(LIM_CAP);
        end
    end

    assign eng_ctl.start = in_acc && (i_action == ACT_SELECT) && (lim_sat != '0);
    assign eng_ctl.limit = lim_sat;

    assign res_last = (CNT_W'(r_k) + CNT_W'(1)) == r_total;

    cap_entry_store #(
        .ENTRIES       (ENTRIES),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (load_wr),
        .i_wr_addr   (IDX_W'(i_entry_index)),
        .i_wr_prio   (PRIORITY_BITS'(i_priority_req)),
        .i_wr_row    (i_conflict_row),
        .i_prio_addr (prio_addr),
        .o_prio_data (prio_data),
        .i_row_addr  (row_addr),
        .o_row_data  (row_data)
    );

    cap_sort_engine #(
        .ENTRIES       (ENTRIES),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (eng_ctl),
        .o_stat      (eng_stat),
        .o_prio_addr (prio_addr),
        .i_prio_data (prio_data),
        .o_row_addr  (row_addr),
        .i_row_data  (row_data),
        .i_sel_addr  (r_k),
        .o_sel_data  (sel_data)
    );

    // Control sequencer and output register. A zero limit skips the engine
    // and sends a single empty word. Otherwise each chosen entry is read
    // from the engine's pick list in the read state and then loaded into the
    // output register as soon as it is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_out_valid <= 1'b0;
            r_total     <= '0;
            r_k         <= '0;
        end else begin
            // In the send state the output register is either reloaded or
            // still stalled, so it is only emptied from the other states.
            if (r_out_valid && !i_out_stall && (r_state != T_SEND)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                T_IDLE: begin
                    if (in_acc && (i_action == ACT_SELECT)) begin
                        r_k <= '0;
                        if (lim_sat == '0) begin
                            r_total <= '0;
                            r_state <= T_SEND;
                        end else begin
                            r_state <= T_RUN;
                        end
                    end
                end
                T_RUN: begin
                    if (eng_stat.done) begin
                        r_total <= eng_stat.count;
                        r_state <= T_READ;
                    end
                end
                T_READ: begin
                    r_state <= T_SEND;
                end
                T_SEND: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_total == '0) begin
                            r_out_index <= '0;
                            r_out_slot  <= '0;
                            r_out_none  <= 1'b1;
                            r_out_total <= '0;
                            r_out_last  <= 1'b1;
                            r_state     <= T_IDLE;
                        end else begin
                            r_out_index <= IDX_IN_W'(sel_data);
                            r_out_slot  <= r_k;
                            r_out_none  <= 1'b0;
                            r_out_total <= r_total;
                            r_out_last  <= res_last;
                            if (res_last) begin
                                r_state <= T_IDLE;
                            end else begin
                                r_k     <= r_k + SEL_W'(1);
                                r_state <= T_READ;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_selected_index = r_out_index;
    assign o_slot           = r_out_slot;
    assign o_none_selected  = r_out_none;
    assign o_total_selected = r_out_total;
    assign o_is_last        = r_out_last;

endmodule

FILE: rtl/cap_checker.sv
// ============================================================================
// Port checker
// Watches the top-level ports for consistent result words over time.
// ============================================================================
module cap_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [cap_pkg::IDX_IN_W-1:0]  o_selected_index,
    input logic [cap_pkg::SEL_W-1:0]     o_slot,
    input logic                          o_none_selected,
    input logic [cap_pkg::CNT_W-1:0]     o_total_selected,
    input logic                          o_is_last
);
    import cap_pkg::*;

    // A stalled result word keeps its valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid after reset");

    // The empty word of a zero limit is the sole, all-zero word.
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_none_selected |->
            o_is_last && (o_total_selected == '0) && (o_slot == '0)
            && (o_selected_index == '0))
        else $error("malformed empty result word");

    // A real pick lies inside its count and ends the selection on its last slot.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_none_selected |->
            (o_total_selected != '0)
            && ((CNT_W'(o_slot) + CNT_W'(1)) <= o_total_selected)
            && (o_is_last == ((CNT_W'(o_slot) + CNT_W'(1)) == o_total_selected)))
        else $error("slot and count disagree");

    // While a selection still has words to send, no new input word enters.
    a_busy_until_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_last |-> o_in_stall)
        else $error("input taken before the selection finished");

endmodule

bind conflict_aware_priority_select_top cap_checker u_cap_checker (.*);

FILE: tb/conflict_aware_priority_select_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Conflict-aware priority select testbench
// Loads priorities and conflict rows into the entry file, runs selections and
// checks every pick word against a behavioral mirror of the sort-and-pick
// rule, or against a hand-written result. A short table of hand-picked words
// comes first, then random words. Both handshakes idle at random, and the result
// side holds off once for a long stretch so the block backs up and stalls its input.
// ============================================================================
module conflict_aware_priority_select_top_tb;

    import cap_pkg::*;

    localparam int N_ENT        = ENTRIES_DEF;
    localparam int RANDOM_WORDS = 120;
    localparam int DRAIN_CYCLES = 400;    // above one full select at 16 entries
    localparam int IDLE_LIMIT   = 4000;   // cycles with no handshake at all
    localparam int HOLD_CYCLES  = 500;    // long result-side hold-off

    // One input word as it is put on the ports.
    typedef struct packed {
        logic                 action;
        logic [IDX_IN_W-1:0]  idx;
        logic [PRIO_IN_W-1:0] prio;
        logic [ROW_W-1:0]     row;
        logic [LIMIT_W-1:0]   limit;
    } t_word;

    // One result word.
    typedef struct packed {
        logic [IDX_IN_W-1:0] idx;
        logic [SEL_W-1:0]    slot;
        logic                none;
        logic [CNT_W-1:0]    total;
        logic                last;
    } t_pick;

    // A row of the directed table. Rows marked pinned carry their single
    // result written out by hand; all other rows go through the mirror.
    typedef struct packed {
        t_word               w;
        logic                pinned;
        logic [IDX_IN_W-1:0] pin_idx;
        logic                pin_none;
        logic [CNT_W-1:0]    pin_total;
    } t_plan_row;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_stall;
    logic                 i_action       = ACT_LOAD;
    logic [IDX_IN_W-1:0]  i_entry_index  = '0;
    logic [PRIO_IN_W-1:0] i_priority_req = '0;
    logic [ROW_W-1:0]     i_conflict_row = '0;
    logic [LIMIT_W-1:0]   i_select_limit = '0;
    logic                 o_out_valid;
    logic                 i_out_stall    = 1'b0;
    logic [IDX_IN_W-1:0]  o_selected_index;
    logic [SEL_W-1:0]     o_slot;
    logic                 o_none_selected;
    logic [CNT_W-1:0]     o_total_selected;
    logic                 o_is_last;

    conflict_aware_priority_select_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_entry_index    (i_entry_index),
        .i_priority_req   (i_priority_req),
        .i_conflict_row   (i_conflict_row),
        .i_select_limit   (i_select_limit),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_selected_index (o_selected_index),
        .o_slot           (o_slot),
        .o_none_selected  (o_none_selected),
        .o_total_selected (o_total_selected),
        .o_is_last        (o_is_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mirror of the entry file and the queue of picks still to come back.
    logic [PRIO_IN_W-1:0] prio_mirror [N_ENT];
    logic [ROW_W-1:0]     row_mirror  [N_ENT];
    t_pick                pending_picks [$];

    int errors       = 0;
    int picks_seen   = 0;
    int loads_sent   = 0;
    int selects_sent = 0;
    int zero_limits  = 0;
    int full_selects = 0;
    int idle_cycles  = 0;
    bit hold_done    = 1'b0;

    // Applies one accepted word to the mirror. A load updates the entry file.
    // A select sorts the entries by descending priority with the exchange
    // sort, walks that order greedily, skipping any candidate whose row hits
    // an entry already kept, and queues one pick per kept entry.
    function automatic void mirror_word(input t_word w);
        int    order [N_ENT];
        int    kept  [N_ENT];
        int    lim;
        int    count;
        int    tmp;
        bit    hit;
        t_pick p;
        if (w.action == ACT_LOAD) begin
            loads_sent++;
            if (int'(w.idx) < N_ENT) begin
                prio_mirror[w.idx] = w.prio;
                row_mirror[w.idx]  = w.row;
            end
            return;
        end
        selects_sent++;
        if (w.limit == 0) begin
            // A zero limit gives one empty result and nothing else.
            zero_limits++;
            p       = '0;
            p.none  = 1'b1;
            p.last  = 1'b1;
            pending_picks.push_back(p);
            return;
        end
        lim = int'(w.limit);
        if (lim > N_ENT) lim = N_ENT;
        if (lim > MAX_RESULTS) lim = MAX_RESULTS;
        for (int i = 0; i < N_ENT; i++) order[i] = i;
        // Only a strictly greater priority swaps, so ties keep whatever
        // order the exchange passes leave them in.
        for (int i = 0; i < N_ENT - 1; i++) begin
            for (int j = i + 1; j < N_ENT; j++) begin
                if (prio_mirror[order[j]] > prio_mirror[order[i]]) begin
                    tmp      = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
            end
        end
        count = 0;
        for (int i = 0; i < N_ENT && count < lim; i++) begin
            hit = 1'b0;
            for (int k = 0; k < count; k++) begin
                if (row_mirror[order[i]][kept[k]]) hit = 1'b1;
            end
            if (!hit) begin
                kept[count] = order[i];
                count++;
            end
        end
        if (count == N_ENT) full_selects++;
        for (int k = 0; k < count; k++) begin
            p.idx   = kept[k][IDX_IN_W-1:0];
            p.slot  = k[SEL_W-1:0];
            p.none  = 1'b0;
            p.total = count[CNT_W-1:0];
            p.last  = (k == count - 1);
            pending_picks.push_back(p);
        end
    endfunction

    // Puts one word on the input port and holds it until it is taken. Called
    // at a rising edge; valid stays high into the next word when there is
    // no gap, so it is only ever assigned once per edge.
    task automatic send_word(input t_word w, input bit pinned, input t_pick pin);
        i_in_valid     <= 1'b1;
        i_action       <= w.action;
        i_entry_index  <= w.idx;
        i_priority_req <= w.prio;
        i_conflict_row <= w.row;
        i_select_limit <= w.limit;
        do @(posedge i_clk); while (o_in_stall);
        if (pinned) begin
            // The word still counts as a select, but its result is the one
            // written in the table rather than the mirror's.
            selects_sent++;
            if (w.limit == 0) zero_limits++;
            pending_picks.push_back(pin);
        end else begin
            mirror_word(w);
        end
    endtask

    // Random word. Most traffic is a few loads followed by a select, with
    // priorities drawn often from a small set so that ties are common.
    function automatic t_word random_word(input bit force_select);
        t_word w;
        int    pick;
        w.idx   = IDX_IN_W'($urandom_range(0, N_ENT - 1));
        w.prio  = $urandom;
        w.row   = ROW_W'($urandom);
        w.limit = LIMIT_W'($urandom);
        w.action = (force_select || $urandom_range(0, 5) == 0) ? ACT_SELECT : ACT_LOAD;
        pick = $urandom_range(0, 9);
        if (pick == 0) w.prio = '0;
        else if (pick == 1) w.prio = '1;
        else if (pick < 6) w.prio = PRIO_IN_W'($urandom_range(0, 3)) << 30;
        pick = $urandom_range(0, 7);
        if (pick == 0) w.row = '0;
        else if (pick == 1) w.row = '1;
        else if (pick < 5) w.row = ROW_W'($urandom & $urandom & $urandom);
        if (w.action == ACT_SELECT) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) w.limit = '0;
            else if (pick == 1) w.limit = LIMIT_W'(N_ENT);
            else if (pick == 2) w.limit = LIMIT_W'($urandom_range(N_ENT + 1, 31));
            else w.limit = LIMIT_W'($urandom_range(1, N_ENT - 1));
        end
        return w;
    endfunction

    // Result side: compare each accepted pick with the oldest one pending.
    always @(posedge i_clk) begin
        t_pick want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            picks_seen <= picks_seen + 1;
            if (pending_picks.size() == 0) begin
                $error("pick word with nothing pending: index %0d slot %0d",
                       o_selected_index, o_slot);
                errors++;
            end else begin
                want = pending_picks.pop_front();
                if (o_selected_index !== want.idx) begin
                    $error("selected_index: expected %0d, got %0d", want.idx, o_selected_index);
                    errors++;
                end
                if (o_slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, o_slot);
                    errors++;
                end
                if (o_none_selected !== want.none) begin
                    $error("none_selected: expected %0d, got %0d", want.none, o_none_selected);
                    errors++;
                end
                if (o_total_selected !== want.total) begin
                    $error("total_selected: expected %0d, got %0d",
                           want.total, o_total_selected);
                    errors++;
                end
                if (o_is_last !== want.last) begin
                    $error("is_last: expected %0d, got %0d", want.last, o_is_last);
                    errors++;
                end
            end
        end
    end

    // Result-side stall pattern: stretches that never stall, stretches of
    // random stalls and stretches of a regular one-in-three stall. Once a
    // good number of picks have come back, the stall is held for a long
    // stretch while the sender keeps offering words.
    initial begin
        int mode;
        int span;
        int phase;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!hold_done && picks_seen >= 24) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                mode  = $urandom_range(0, 2);
                span  = $urandom_range(10, 60);
                phase = 0;
                repeat (span) begin
                    case (mode)
                        0: begin
                            i_out_stall <= 1'b0;
                        end
                        1: begin
                            i_out_stall <= ($urandom_range(0, 9) < 4);
                        end
                        default: begin
                            i_out_stall <= (phase == 2);
                        end
                    endcase
                    phase = (phase + 1) % 3;
                    @(posedge i_clk);
                end
            end
        end
    end

    // Watchdog: any handshake on either side restarts the count.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        t_plan_row plan [16];
        t_pick     pin;
        t_word     w;
        int        burst;
        int        gap;
        int        sent;
        bit        want_select;

        for (int i = 0; i < N_ENT; i++) begin
            prio_mirror[i] = '0;
            row_mirror[i]  = '0;
        end

        // Directed table. The first selects run on the reset state, where
        // every priority is zero and no swap happens, so entry 0 leads.
        plan[0]  = '{'{ACT_SELECT, 4'd9,  32'hDEADBEEF, 16'hFFFF, 5'd0},  1'b1, 4'd0,  1'b1, 5'd0};
        plan[1]  = '{'{ACT_SELECT, 4'd0,  32'h0,        16'h0,    5'd1},  1'b1, 4'd0,  1'b0, 5'd1};
        plan[2]  = '{'{ACT_SELECT, 4'd15, 32'hFFFFFFFF, 16'hFFFF, 5'd16}, 1'b0, 4'd0,  1'b0, 5'd0};
        plan[3]  = '{'{ACT_LOAD,   4'd15, 32'hFFFFFFFF, 16'h0000, 5'd31}, 1'b0, 4'd0,  1'b0, 5'd0};
        plan[4]  = '{'{ACT_SELECT, 4'd0,  32'h0,        16'h0,    5'd1},  1'b1, 4'd15, 1'b0, 5'd1};
        plan[5]  = '{'{ACT_LOAD,   4'd0,  32'h80000000, 16'hFFFF, 5'd0},  1'b0, 4'd0,  1'b0, 5'd0};
        plan[6]  = '{'{ACT_LOAD,   4'd7,  32'h80000000, 16'h0000, 5'd16}, 1'b0, 4'd0,  1'b0, 5'd0};
        plan[7]  = '{'{ACT_LOAD,   4'd3,  32'h00000001, 16'h8000, 5'd5},  1'b0, 4'd0,  1'b0, 5'd0};
        plan[8]  = '{'{ACT_SELECT, 4'd3,  32'h12345678, 16'h0F0F, 5'd31}, 1'b0, 4'd0,  1'b0, 5'd0};
        plan[9]  = '{'{ACT_SELECT, 4'd0,  32'h0,        16'h0,    5'd17}, 1'b0, 4'd0,  1'b0, 5'd0};
        plan[10] = '{'{ACT_LOAD,   4'd5,  32'h7FFFFFFF, 16'h5555, 5'd0},  1'b0, 4'd0,  1'b0, 5'd0};
        plan[11] = '{'{ACT_LOAD,   4'd10, 32'h80000001, 16'hAAAA, 5'd0},  1'b0, 4'd0,  1'b0, 5'd0};
        plan[12] = '{'{ACT_SELECT, 4'd0,  32'h0,        16'h0,    5'd2},  1'b0, 4'd0,  1'b0, 5'd0};
        plan[13] = '{'{ACT_LOAD,   4'd8,  32'h00000000, 16'hFFFF, 5'd16}, 1'b0, 4'd0,  1'b0, 5'd0};
        plan[14] = '{'{ACT_SELECT, 4'd8,  32'hFFFFFFFF, 16'hFFFF, 5'd16}, 1'b0, 4'd0,  1'b0, 5'd0};
        plan[15] = '{'{ACT_SELECT, 4'd1,  32'h1,        16'h1,    5'd0},  1'b1, 4'd0,  1'b1, 5'd0};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words back to back, no idling.
        foreach (plan[r]) begin
            pin       = '0;
            pin.idx   = plan[r].pin_idx;
            pin.none  = plan[r].pin_none;
            pin.total = plan[r].pin_total;
            pin.last  = 1'b1;
            send_word(plan[r].w, plan[r].pinned, pin);
        end

        // Random words in bursts, with random gaps that are sometimes zero.
        // A burst mostly ends in a select so that loads keep being tested.
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst && sent < RANDOM_WORDS; b++) begin
                want_select = (b == burst - 1) && ($urandom_range(0, 3) != 0);
                w = random_word(want_select);
                send_word(w, 1'b0, '0);
                sent++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;

        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d loads and %0d selects (%0d with a zero limit, %0d keeping all entries).",
                 loads_sent, selects_sent, zero_limits, full_selects);
        $display("Checked %0d pick words; the input was backed up by a %0d-cycle result hold.",
                 picks_seen, HOLD_CYCLES);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
